// ===== rtl/b64d_pkg.sv =====
`timescale 1ns / 1ps
// b64d_pkg: shared types, constants and the alphabet lookup for the base64url decoder
package b64d_pkg;

   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   localparam logic [7:0] PAD_CHAR = 8'h3D;
   localparam logic [2:0] MAX_PAD  = 3'd2;
   localparam logic [2:0] SAT_MAX  = 3'd7;
   localparam logic [1:0] LAST_POS = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_LEN  = 2'd1;
   localparam logic [1:0] ST_BAD_CHAR = 2'd2;
   localparam logic [1:0] ST_BAD_PAD  = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic [1:0] status;
      logic       end_of_output;
   } result_type;

   typedef struct packed {
      logic [1:0]       count;
      result_type [2:0] entry;
   } push_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2D) begin
         s.value = 6'd62;
      end else if (c == 8'h5F) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

   // bytes carried by a padded group, capped at three
   function automatic logic [1:0] bytes_of(input logic [2:0] sextets);
      logic [1:0] n;
      unique case (sextets)
         3'd0, 3'd1: n = 2'd0;
         3'd2:       n = 2'd1;
         3'd3:       n = 2'd2;
         default:    n = 2'd3;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/b64d_if.sv =====
`timescale 1ns / 1ps
// b64d_if: valid/ready channel interfaces for character and result items
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       final_char;

   modport source (output valid, output char_code, output final_char, input ready);
   modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_data;
   logic [1:0] status;
   logic       end_of_output;

   modport source (output valid, output data_byte, output has_data, output status,
                   output end_of_output, input ready);
   modport sink   (input valid, input data_byte, input has_data, input status,
                   input end_of_output, output ready);
endinterface

// ===== rtl/b64d_core.sv =====
`timescale 1ns / 1ps
// b64d_core: input register, group state and per-item result generation
module b64d_core (
   input  logic               clock,
   input  logic               reset,
   b64d_req_if.sink           req,
   input  logic               space_ok,
   output b64d_pkg::push_type push
);
   import b64d_pkg::*;

   logic        stage_valid_ff, stage_valid_in;
   logic [7:0]  stage_char_ff;
   logic        stage_final_ff;
   logic [23:0] group_ff, group_in;
   logic [1:0]  pos_ff, pos_in;
   logic [2:0]  sext_ff, sext_in;
   logic [2:0]  pad_ff, pad_in;
   logic [1:0]  err_ff, err_in;
   logic        fire;
   logic        take;

   assign fire      = stage_valid_ff && space_ok;
   assign req.ready = !stage_valid_ff || fire;
   assign take      = req.valid && req.ready;
   assign stage_valid_in = take ? 1'b1 : (fire ? 1'b0 : stage_valid_ff);

   always_comb begin
      sextet_type  s;
      logic [23:0] g;
      logic [2:0]  sx;
      logic [2:0]  pd;
      logic [1:0]  er;
      logic [1:0]  st;
      logic [1:0]  nb;
      logic        completes;
      s  = sextet_of(stage_char_ff);
      g  = group_ff;
      sx = sext_ff;
      pd = pad_ff;
      er = err_ff;
      completes = (pos_ff == LAST_POS);
      if (err_ff == ST_OK) begin
         if (stage_char_ff == PAD_CHAR) begin
            if (pd != SAT_MAX) pd = pd + 3'd1;
            if (pd > MAX_PAD) er = ST_BAD_PAD;
            g = {g[17:0], 6'd0};
         end else if (pad_ff != 3'd0) begin
            er = ST_BAD_PAD;
         end else if (!s.valid) begin
            er = ST_BAD_CHAR;
         end else begin
            g = {g[17:0], s.value};
            if (sx != SAT_MAX) sx = sx + 3'd1;
         end
      end

      st = completes ? er : ST_BAD_LEN;
      nb = 2'd0;
      if (st == ST_OK) nb = (pd == 3'd0) ? 2'd3 : bytes_of(sx);

      push.count = 2'd0;
      for (int i = 0; i < 3; i++) begin
         push.entry[i].data_byte     = g[23 - 8*i -: 8];
         push.entry[i].has_data      = 1'b1;
         push.entry[i].status        = ST_OK;
         push.entry[i].end_of_output = 1'b0;
      end

      pos_in  = pos_ff + 2'd1;
      group_in = g;
      sext_in  = sx;
      pad_in   = pd;
      err_in   = er;

      if (stage_final_ff) begin
         if (nb == 2'd0) begin
            push.count = 2'd1;
            push.entry[0].data_byte     = 8'd0;
            push.entry[0].has_data      = 1'b0;
            push.entry[0].status        = st;
            push.entry[0].end_of_output = 1'b1;
         end else begin
            push.count = nb;
            push.entry[nb - 2'd1].status        = st;
            push.entry[nb - 2'd1].end_of_output = 1'b1;
         end
         pos_in   = 2'd0;
         group_in = 24'd0;
         sext_in  = 3'd0;
         pad_in   = 3'd0;
         err_in   = ST_OK;
      end else if (completes) begin
         if (er == ST_OK && pd == 3'd0) push.count = 2'd3;
         group_in = 24'd0;
         sext_in  = 3'd0;
      end

      if (!fire) push.count = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_char_ff  <= req.char_code;
         stage_final_ff <= req.final_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         group_ff       <= 24'd0;
         pos_ff         <= 2'd0;
         sext_ff        <= 3'd0;
         pad_ff         <= 3'd0;
         err_ff         <= ST_OK;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (fire) begin
            group_ff <= group_in;
            pos_ff   <= pos_in;
            sext_ff  <= sext_in;
            pad_ff   <= pad_in;
            err_ff   <= err_in;
         end
      end
   end

endmodule

// ===== rtl/b64d_rsp_fifo.sv =====
`timescale 1ns / 1ps
// b64d_rsp_fifo: result buffer taking up to three items a cycle, giving one while rsp.ready is high
module b64d_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  b64d_pkg::push_type push,
   output logic               space_ok,
   b64d_rsp_if.source         rsp
);
   import b64d_pkg::*;

   result_type           mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   result_type           head;

   assign head     = mem[rd_ptr_ff];
   assign rsp.valid         = (count_ff != '0);
   assign rsp.data_byte     = head.data_byte;
   assign rsp.has_data      = head.has_data;
   assign rsp.status        = head.status;
   assign rsp.end_of_output = head.end_of_output;

   assign pop      = rsp.valid && rsp.ready;
   assign space_ok = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 3));

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push.count) begin
            mem[wr_ptr_ff + RSP_PTR_W'(i)] <= push.entry[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/base64url_stream_decoder.sv =====
`timescale 1ns / 1ps
// base64url_stream_decoder: top level of the streaming base64url decoder
//
//   channel   direction  handshake     payload
//   req_ch    in         valid/ready   char_code[7:0], final_char
//   rsp_ch    out        valid/ready   data_byte[7:0], has_data, status[1:0], end_of_output
//
// one character item accepted per cycle unless the input register stalls
// a character stays in the input register until the buffer has room, and there the group logic runs
// up to three result items per character go into an eight-entry result buffer
// the input register stalls while fewer than three buffer entries are free
// synchronous reset clears group state, error and buffer pointers
module base64url_stream_decoder (
   input logic        clock,
   input logic        reset,
   b64d_req_if.sink   req_ch,
   b64d_rsp_if.source rsp_ch
);
   import b64d_pkg::*;

   push_type push;
   logic     space_ok;

   b64d_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .space_ok (space_ok),
      .push     (push)
   );

   b64d_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_ch)
   );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for the base64url stream decoder
module tb_top;
   import b64d_pkg::*;

   typedef enum int {
      SHAPE_CLEAN,
      SHAPE_SHORT_TAIL,
      SHAPE_PAD_THEN_DATA,
      SHAPE_CORRUPT,
      SHAPE_EXTRA_PAD,
      SHAPE_LENGTH_OFF,
      SHAPE_NOISE
   } stream_shape_type;

   logic clock;
   logic reset;

   b64d_req_if req_ch ();
   b64d_rsp_if rsp_ch ();

   base64url_stream_decoder dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   logic [23:0] grp_bits;
   logic [1:0]  grp_pos;
   logic [2:0]  grp_sextets;
   logic [2:0]  pad_seen;
   logic [1:0]  err_code;

   result_type  decoded_q[$];
   logic [7:0]  text_q[$];

   int unsigned mismatch_count;
   int unsigned results_checked;
   int unsigned chars_sent;
   int unsigned strings_sent;
   bit          send_gaps;
   bit          rsp_gaps;
   bit          rsp_hold;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int sextet_value(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == "-") return 62;
      if (c == "_") return 63;
      return 64;
   endfunction

   function automatic logic [7:0] sextet_char(input int v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      if (v == 62) return "-";
      return "_";
   endfunction

   function automatic void push_result(input logic [7:0] b, input logic has,
                                       input logic [1:0] st, input logic eoo);
      result_type r;
      r.data_byte     = b;
      r.has_data      = has;
      r.status        = st;
      r.end_of_output = eoo;
      decoded_q.push_back(r);
   endfunction

   function automatic void clear_group();
      grp_bits    = '0;
      grp_pos     = '0;
      grp_sextets = '0;
      pad_seen    = '0;
      err_code    = ST_OK;
   endfunction

   function automatic void decode_char(input logic [7:0] c, input logic last_char);
      logic       completes;
      logic [1:0] st;
      int         s;
      int         nb;
      completes = (grp_pos == LAST_POS);
      if (err_code == ST_OK) begin
         if (c == PAD_CHAR) begin
            if (pad_seen < SAT_MAX) pad_seen = pad_seen + 3'd1;
            if (pad_seen > MAX_PAD) err_code = ST_BAD_PAD;
            grp_bits = grp_bits << 6;
         end else if (pad_seen != 3'd0) begin
            err_code = ST_BAD_PAD;
         end else begin
            s = sextet_value(c);
            if (s > 63) begin
               err_code = ST_BAD_CHAR;
            end else begin
               grp_bits = {grp_bits[17:0], 6'(s)};
               if (grp_sextets < SAT_MAX) grp_sextets = grp_sextets + 3'd1;
            end
         end
      end
      grp_pos = grp_pos + 2'd1;
      if (last_char) begin
         st = completes ? err_code : ST_BAD_LEN;
         nb = 0;
         if (st == ST_OK) begin
            nb = (pad_seen == 3'd0) ? 3 : (int'(grp_sextets) * 6) / 8;
            if (nb > 3) nb = 3;
         end
         for (int i = 0; i < nb; i++) begin
            push_result(grp_bits[16 - 8 * i +: 8], 1'b1, (i == nb - 1) ? st : ST_OK,
                        i == nb - 1);
         end
         if (nb == 0) push_result(8'h00, 1'b0, st, 1'b1);
         clear_group();
      end else if (completes) begin
         // a padded group yields no bytes here; only a padded group ending in the final character is emitted
         if (err_code == ST_OK && pad_seen == 3'd0) begin
            for (int i = 0; i < 3; i++) push_result(grp_bits[16 - 8 * i +: 8], 1'b1, ST_OK, 1'b0);
         end
         grp_bits    = '0;
         grp_sextets = '0;
      end
   endfunction

   function automatic void append_literal(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic void append_group(input int nbytes, input bit padded);
      logic [23:0] g;
      g = 24'($urandom);
      for (int i = 0; i <= nbytes; i++) text_q.push_back(sextet_char(int'(g[18 - 6 * i +: 6])));
      if (padded) begin
         for (int i = nbytes + 1; i < 4; i++) text_q.push_back(PAD_CHAR);
      end
   endfunction

   function automatic void flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic last_char);
      int unsigned gap;
      gap = 0;
      if (send_gaps && $urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.char_code  <= c;
      req_ch.final_char <= last_char;
      do @(posedge clock); while (!req_ch.ready);
      decode_char(c, last_char);
      chars_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
      strings_sent++;
      text_q.delete();
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (decoded_q.size() != 0);
   endtask

   task automatic hold_receiver(input int unsigned cycles);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (cycles) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
   endtask

   task automatic test_directed();
      send_gaps = 1'b0;
      rsp_gaps <= 1'b0;
      append_literal("__-A");
      send_text();
      append_literal("AAz9");
      send_text();
      append_literal("QQ==");
      send_text();
      append_literal("Qmz=");
      send_text();
      append_literal("A");
      send_text();
      text_q.push_back(8'hFF);
      append_literal("AAA");
      send_text();
      append_literal("A===");
      send_text();
      append_literal("AB=C");
      send_text();
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_gaps = 1'b0;
      rsp_gaps <= 1'b0;
      hold_receiver(300);
      for (int n = 0; n < 6; n++) begin
         for (int g = 0; g < 3; g++) append_group(3, 1'b0);
         send_text();
      end
      wait_drained();
   endtask

   task automatic test_random_streams(input int unsigned count);
      int unsigned      stop_at;
      int unsigned      r;
      int               tail;
      int               idx;
      stream_shape_type shape;
      stop_at = chars_sent + count;
      send_gaps = 1'b1;
      rsp_gaps <= 1'b1;
      while (chars_sent < stop_at) begin
         r = $urandom_range(0, 15);
         if (r < 8) shape = SHAPE_CLEAN;
         else if (r == 8) shape = SHAPE_SHORT_TAIL;
         else if (r == 9) shape = SHAPE_PAD_THEN_DATA;
         else if (r < 12) shape = SHAPE_CORRUPT;
         else if (r == 12) shape = SHAPE_EXTRA_PAD;
         else if (r == 13) shape = SHAPE_LENGTH_OFF;
         else shape = SHAPE_NOISE;

         repeat ($urandom_range(0, 2)) append_group(3, 1'b0);
         tail = $urandom_range(0, 2);
         case (shape)
            SHAPE_SHORT_TAIL: begin
               append_group((tail == 0) ? 1 : tail, 1'b0);
            end
            SHAPE_PAD_THEN_DATA: begin
               append_group($urandom_range(1, 2), 1'b1);
               append_group(3, 1'b0);
            end
            SHAPE_EXTRA_PAD: begin
               append_group(1, 1'b1);
               repeat ($urandom_range(1, 2)) text_q.push_back(PAD_CHAR);
            end
            SHAPE_NOISE: begin
               repeat ($urandom_range(1, 8)) begin
                  r = $urandom_range(0, 3);
                  if (r == 0) text_q.push_back(PAD_CHAR);
                  else if (r == 1) text_q.push_back(8'($urandom_range(0, 255)));
                  else text_q.push_back(sextet_char($urandom_range(0, 63)));
               end
            end
            default: begin
               if (tail == 0) append_group(3, 1'b0);
               else append_group(tail, 1'b1);
               if (shape == SHAPE_CORRUPT) begin
                  idx = $urandom_range(0, text_q.size() - 1);
                  text_q[idx] = 8'($urandom_range(0, 255));
               end else if (shape == SHAPE_LENGTH_OFF) begin
                  if ($urandom_range(0, 1) == 0 && text_q.size() > 1) void'(text_q.pop_back());
                  else text_q.push_back(sextet_char($urandom_range(0, 63)));
               end
            end
         endcase
         send_text();
         if ($urandom_range(0, 19) == 0) wait_drained();
         if ($urandom_range(0, 7) == 0) begin
            send_gaps = $urandom_range(0, 2) != 0;
            rsp_gaps <= $urandom_range(0, 2) != 0;
         end
      end
   endtask

   // receiver: random stalls plus the long hold-off
   initial begin
      int unsigned stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      got.data_byte     = rsp_ch.data_byte;
      got.has_data      = rsp_ch.has_data;
      got.status        = rsp_ch.status;
      got.end_of_output = rsp_ch.end_of_output;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_checked++;
         if (decoded_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected item byte %02h has %0d status %0d end %0d",
                                    got.data_byte, got.has_data, got.status,
                                    got.end_of_output));
         end else begin
            want = decoded_q.pop_front();
            if (got.data_byte !== want.data_byte || got.has_data !== want.has_data ||
                got.status !== want.status || got.end_of_output !== want.end_of_output) begin
               flag_mismatch($sformatf(
                  "expected byte %02h has %0d status %0d end %0d, got %02h %0d %0d %0d",
                  want.data_byte, want.has_data, want.status, want.end_of_output,
                  got.data_byte, got.has_data, got.status, got.end_of_output));
            end
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.char_code  <= 8'h00;
      req_ch.final_char <= 1'b0;
      clear_group();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_streams(330);
      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d strings, %0d characters, %0d result items checked",
               strings_sent, chars_sent, results_checked);
      $display("directed error cases, a 300-cycle output stall and random idling included");
      if (mismatch_count == 0 && decoded_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
